[rtl/ice_pkg.sv]
// Package: shared types, constants and the uint32-to-float conversion.
package ice_pkg;

   localparam int MaxChannels = 16;
   localparam int MaxRepeat   = 255;
   localparam int ChanWidth   = $clog2(MaxChannels);
   localparam int RepWidth    = $clog2(MaxRepeat + 1);

   localparam logic [1:0] ModeSimultaneous = 2'd0;
   localparam logic [1:0] ModeSyncMultiple = 2'd1;

   localparam logic CmdRuleLoad = 1'b0;
   localparam logic CmdDataWord = 1'b1;

   localparam logic [2:0] RegScanMode      = 3'd0;
   localparam logic [2:0] RegChannelCount  = 3'd1;
   localparam logic [2:0] RegTargetChannel = 3'd2;
   localparam logic [2:0] RegTargetUnsigned = 3'd3;
   localparam logic [2:0] RegLittleEndian  = 3'd4;
   localparam logic [2:0] RegFrameLimit    = 3'd5;

   typedef struct packed {
      logic       fixed;
      logic [7:0] coeff;
   } rule_type;

   typedef struct packed {
      logic [1:0]  scan_mode;
      logic [4:0]  channel_count;
      logic [3:0]  target_channel;
      logic        target_is_unsigned;
      logic        little_endian_file;
      logic [31:0] frame_limit;
   } cfg_type;

   // uint32 to single precision, round to nearest, ties to even
   function automatic logic [31:0] u32_to_f32(input logic [31:0] u);
      logic [4:0]  e;
      logic [31:0] norm;
      logic [24:0] m;
      logic        guard;
      logic        sticky;
      logic [7:0]  ex;
      e = 5'd0;
      for (int i = 0; i < 32; i++) begin
         if (u[i]) e = 5'(i);
      end
      norm   = u << (5'd31 - e);
      m      = {1'b0, norm[31:8]};
      guard  = norm[7];
      sticky = |norm[6:0];
      if (guard && (sticky || m[0])) m = m + 25'd1;
      ex = 8'(e) + 8'd127;
      if (m[24]) begin
         m  = m >> 1;
         ex = ex + 8'd1;
      end
      if (u == 32'd0) return 32'd0;
      return {1'b0, ex, m[22:0]};
   endfunction

endpackage

[rtl/ice_csr.sv]
// Configuration registers behind the APB-style port.
module ice_csr (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_psel,
   input  logic                 csr_penable,
   input  logic                 csr_pwrite,
   input  logic [4:0]           csr_paddr,
   input  logic [31:0]          csr_pwdata,
   output logic [31:0]          csr_prdata,
   output logic                 csr_pready,
   output ice_pkg::cfg_type     cfg
);
   import ice_pkg::*;

   cfg_type    cfg_ff;
   logic       wr;
   logic [2:0] idx;

   assign csr_pready = 1'b1;
   assign idx = csr_paddr[4:2];
   assign wr  = csr_psel && csr_penable && csr_pwrite;
   assign cfg = cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '{scan_mode: 2'd0, channel_count: 5'd1, target_channel: 4'd0,
                     target_is_unsigned: 1'b0, little_endian_file: 1'b1,
                     frame_limit: 32'd0};
      end else if (wr) begin
         unique case (idx)
            RegScanMode:       cfg_ff.scan_mode          <= csr_pwdata[1:0];
            RegChannelCount:   cfg_ff.channel_count      <= csr_pwdata[4:0];
            RegTargetChannel:  cfg_ff.target_channel     <= csr_pwdata[3:0];
            RegTargetUnsigned: cfg_ff.target_is_unsigned <= csr_pwdata[0];
            RegLittleEndian:   cfg_ff.little_endian_file <= csr_pwdata[0];
            RegFrameLimit:     cfg_ff.frame_limit        <= csr_pwdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (idx)
         RegScanMode:       csr_prdata = {30'd0, cfg_ff.scan_mode};
         RegChannelCount:   csr_prdata = {27'd0, cfg_ff.channel_count};
         RegTargetChannel:  csr_prdata = {28'd0, cfg_ff.target_channel};
         RegTargetUnsigned: csr_prdata = {31'd0, cfg_ff.target_is_unsigned};
         RegLittleEndian:   csr_prdata = {31'd0, cfg_ff.little_endian_file};
         RegFrameLimit:     csr_prdata = cfg_ff.frame_limit;
         default:           csr_prdata = 32'd0;
      endcase
   end

endmodule

[rtl/interleaved_channel_extractor.sv]
// Top level: channel demultiplexer with rule table and float conversion.
//
// Input channel req_*: one transfer per cycle when ready. command 0 loads a
// channel rule (fixed flag, words per frame), command 1 carries one 32-bit
// data word. Output channel rsp_*: zero or one transfer per input transfer, carrying
// the target channel's sample as single-precision bits and its position
// among the target's words in the frame.
// A result is registered and presented in the cycle after its input transfer.
// Throughput: one input transfer per cycle while req_tready is high; the frame
// counters, the rule table lookup and the conversion are all combinational.
// The single output register is refilled in the same cycle it is drained,
// so req_tready only drops while a result waits and rsp_tready is low.
// Reset clears the rule table (all channels one word per frame), counters,
// output valid and the configuration registers to their defaults.
// The user must write configuration (csr_*) only while the stream is idle; the block itself does not enforce this.
module interleaved_channel_extractor (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [47:0] req_tdata,  // rule_channel[3:0], rule_fixed[4],
                                   // rule_coeff[12:5], data_word[44:13], zero[47:45]
   input  logic        req_tuser,  // command
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,  // sample_bits[31:0], sample_in_frame[39:32]
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [4:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   import ice_pkg::*;

   cfg_type     cfg;
   rule_type    rule_ff [MaxChannels];
   logic [ChanWidth-1:0] chan_ff, chan_in;
   logic [RepWidth-1:0]  rep_ff, rep_in;
   logic [31:0] frames_ff, frames_in;
   logic        out_valid_ff;
   logic [39:0] out_data_ff;

   // tdata fields (lowest first): rule_channel, rule_fixed, rule_coeff,
   // data_word; top three bits are padding
   logic [3:0]  rule_channel;
   logic        rule_fixed;
   logic [7:0]  rule_coeff;
   logic [31:0] data_word;
   logic        accept, data_ok, emit, last_rep, last_chan;
   logic [4:0]  cc;
   logic [7:0]  count;
   logic [31:0] word;
   rule_type    cur_rule;

   assign rule_channel = req_tdata[3:0];
   assign rule_fixed   = req_tdata[4];
   assign rule_coeff   = req_tdata[12:5];
   assign data_word    = req_tdata[44:13];

   ice_csr u_csr (
      .clock, .reset, .csr_psel, .csr_penable, .csr_pwrite, .csr_paddr,
      .csr_pwdata, .csr_prdata, .csr_pready, .cfg
   );

   assign req_tready = !out_valid_ff || rsp_tready;
   assign accept     = req_tvalid && req_tready;
   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;

   always_comb begin
      cc = (cfg.channel_count > 5'(MaxChannels)) ? 5'(MaxChannels) : cfg.channel_count;
      cur_rule = rule_ff[chan_ff];
      if (cfg.scan_mode == ModeSimultaneous || cur_rule.fixed) count = 8'd1;
      else if (cur_rule.coeff == 8'd0) count = 8'd1;
      else count = cur_rule.coeff;
      word = cfg.little_endian_file ? data_word :
             {data_word[7:0], data_word[15:8], data_word[23:16], data_word[31:24]};
      data_ok = (req_tuser == CmdDataWord) && (cfg.scan_mode <= ModeSyncMultiple)
                && (cc != 5'd0) && (frames_ff < cfg.frame_limit);
      emit = data_ok && ({1'b0, chan_ff} == {1'b0, cfg.target_channel})
             && ({1'b0, cfg.target_channel} < cc);
      last_rep  = ({1'b0, rep_ff} + 9'd1) >= {1'b0, count};
      last_chan = ({1'b0, chan_ff} + 5'd1) >= cc;
      chan_in = chan_ff;
      rep_in = rep_ff;
      frames_in = frames_ff;
      if (accept && data_ok) begin
         if (last_rep) begin
            rep_in = '0;
            if (last_chan) begin
               chan_in = '0;
               frames_in = frames_ff + 32'd1;
            end else chan_in = chan_ff + 1'b1;
         end else rep_in = rep_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         chan_ff <= '0;
         rep_ff <= '0;
         frames_ff <= '0;
         out_valid_ff <= 1'b0;
         for (int i = 0; i < MaxChannels; i++) rule_ff[i] <= '0;
      end else begin
         chan_ff <= chan_in;
         rep_ff <= rep_in;
         frames_ff <= frames_in;
         if (accept && req_tuser == CmdRuleLoad)
            rule_ff[rule_channel] <= '{fixed: rule_fixed, coeff: rule_coeff};
         if (accept) out_valid_ff <= emit;
         else if (rsp_tready) out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept && emit)
         out_data_ff <= {8'(rep_ff),
                         cfg.target_is_unsigned ? u32_to_f32(word) : word};
   end

endmodule
